// ===== src/srpr_pkg.sv =====
package srpr_pkg;

   // counter width default for the watchdog counters
   localparam int unsigned COUNTER_BITS_DEF = 24;

   // field widths
   localparam int unsigned BUDGET_W  = 18;
   localparam int unsigned TARGET_W  = 7;
   localparam int unsigned PCT_W     = 15;
   localparam int unsigned RATING_W  = 16;
   localparam int unsigned DZONE_W   = 8;
   localparam int unsigned GAIN_W    = 16;
   localparam int unsigned STEP_W    = 15;
   localparam int unsigned TICKS_W   = 24;

   // config port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // datapath widths
   localparam int unsigned PROD_W     = GAIN_W + BUDGET_W;   // gain * |budget|
   localparam int unsigned NUM_W      = PROD_W + 7;          // times 100
   localparam int unsigned DIVIDEND_W = NUM_W - 4;           // divide by 16 up front
   localparam int unsigned QUOT_W     = 16;
   localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
   localparam int unsigned SCALE_PCT  = 100;
   localparam int unsigned FULL_SCALE_Q8 = 25600;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PERCENT_MODE  = 3'd0,
      REG_RATED_POWER   = 3'd1,
      REG_DEAD_ZONE     = 3'd2,
      REG_ERROR_GAIN    = 3'd3,
      REG_STEP_LIMIT    = 3'd4,
      REG_WD_TIMEOUT    = 3'd5,
      REG_WD_RECOVERY   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                percent_mode;
      logic [RATING_W-1:0] rated_power;
      logic [DZONE_W-1:0]  dead_zone;
      logic [GAIN_W-1:0]   error_gain;
      logic [STEP_W-1:0]   step_limit;
      logic [TICKS_W-1:0]  wd_timeout;
      logic [TICKS_W-1:0]  wd_recovery;
   } cfg_type;

   typedef struct packed {
      logic done;   // one-cycle pulse, quotient valid
      logic ovf;    // quotient does not fit QUOT_W bits
   } div_status_type;

endpackage

// ===== src/srpr_req_if.sv =====
interface srpr_req_if import srpr_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [BUDGET_W-1:0] budget_watts;
   logic [TARGET_W-1:0]        target_percent;
   logic                       control_enable;
   logic                       boost;
   logic                       fault;
   logic                       link_kick;

   modport source (
      output valid, budget_watts, target_percent, control_enable, boost, fault, link_kick,
      input  ready
   );
   modport sink (
      input  valid, budget_watts, target_percent, control_enable, boost, fault, link_kick,
      output ready
   );
endinterface

// ===== src/srpr_rsp_if.sv =====
interface srpr_rsp_if import srpr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] output_percent_q8;
   logic             output_changed;
   logic             watchdog_holding;

   modport source (
      output valid, output_percent_q8, output_changed, watchdog_holding,
      input  ready
   );
   modport sink (
      input  valid, output_percent_q8, output_changed, watchdog_holding,
      output ready
   );
endinterface

// ===== src/srpr_csr.sv =====
module srpr_csr import srpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PERCENT_MODE: cfg_in.percent_mode = csr_wdata[0];
            REG_RATED_POWER:  cfg_in.rated_power  = csr_wdata[RATING_W-1:0];
            REG_DEAD_ZONE:    cfg_in.dead_zone    = csr_wdata[DZONE_W-1:0];
            REG_ERROR_GAIN:   cfg_in.error_gain   = csr_wdata[GAIN_W-1:0];
            REG_STEP_LIMIT:   cfg_in.step_limit   = csr_wdata[STEP_W-1:0];
            REG_WD_TIMEOUT:   cfg_in.wd_timeout   = csr_wdata[TICKS_W-1:0];
            REG_WD_RECOVERY:  cfg_in.wd_recovery  = csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.percent_mode <= 1'b0;
         cfg_ff.rated_power  <= RATING_W'(2000);
         cfg_ff.dead_zone    <= DZONE_W'(10);
         cfg_ff.error_gain   <= GAIN_W'(4096);
         cfg_ff.step_limit   <= STEP_W'(256);
         cfg_ff.wd_timeout   <= '0;
         cfg_ff.wd_recovery  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/srpr_wdog.sv =====
module srpr_wdog import srpr_pkg::*; #(
   parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick,
   input  logic               kick,
   input  logic               clear,
   input  logic [TICKS_W-1:0] timeout,
   input  logic [TICKS_W-1:0] recovery,
   output logic               holding
);

   localparam int unsigned XW = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;
   localparam logic [COUNTER_BITS-1:0] CMAX = '1;

   logic [COUNTER_BITS-1:0] ticks_ff, ticks_in;
   logic [COUNTER_BITS-1:0] hold_ff, hold_in;
   logic [COUNTER_BITS-1:0] limit, rec_lim, tk;
   logic [XW-1:0]           tmo_x, rec_x, cmax_x;

   // settings wider than the counter saturate to its maximum
   assign tmo_x   = XW'(timeout);
   assign rec_x   = XW'(recovery);
   assign cmax_x  = XW'(CMAX);
   assign limit   = (tmo_x > cmax_x) ? CMAX : tmo_x[COUNTER_BITS-1:0];
   assign rec_lim = (rec_x > cmax_x) ? CMAX : rec_x[COUNTER_BITS-1:0];
   assign tk      = kick ? '0 : ticks_ff;

   always_comb begin
      ticks_in = ticks_ff;
      hold_in  = hold_ff;
      if (clear) begin
         hold_in = '0;
      end else if (tick) begin
         ticks_in = tk;
         if (timeout != '0) begin
            if (tk < limit) begin
               ticks_in = tk + 1'b1;
               if (hold_ff != '0) hold_in = hold_ff - 1'b1;
            end else begin
               hold_in = rec_lim;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
         hold_ff  <= '0;
      end else begin
         ticks_ff <= ticks_in;
         hold_ff  <= hold_in;
      end
   end

   assign holding = (hold_ff != '0);

endmodule

// ===== src/srpr_div.sv =====
module srpr_div import srpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [RATING_W-1:0]   divisor,
   output logic [QUOT_W-1:0]     quot,
   output div_status_type        status
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [RATING_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   logic                  ovf_ff, ovf_in;
   logic [RATING_W:0]     rem_sh, diff;
   logic                  ge;

   // restoring division, one quotient bit a cycle; a zero divisor gives all ones
   assign rem_sh = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign ge     = (rem_sh >= {1'b0, divisor});
   assign diff   = rem_sh - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
         num_in  = dividend;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         num_in  = {num_ff[DIVIDEND_W-2:0], 1'b0};
         rem_in  = ge ? diff[RATING_W-1:0] : rem_sh[RATING_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         ovf_in  = ovf_ff | quot_ff[QUOT_W-1];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
   end

   assign quot        = quot_ff;
   assign status.done = done_ff;
   assign status.ovf  = ovf_ff;

endmodule

// ===== src/slew_limited_power_regulator_core.sv =====
// Channel   Dir  Handshake       Payload
// req_ch    in   valid/ready     budget_watts, target_percent, control_enable, boost,
//                                fault, link_kick
// rsp_ch    out  valid/ready     output_percent_q8, output_changed, watchdog_holding
// csr_*     in   csr_we          csr_index, csr_wdata (no read-back)
//
// One item goes from accept to registered result through a multiply step, a scale
// step, the bit-serial divider by the rated power, the divider's done flag, then the
// apply step. A new item is accepted only after the previous one has been applied.
// req_ch.ready is high only while the sequencer is idle.
// A result held in the output register does not block the next accept; the apply
// cycle waits there until the previous result is taken.
// Reset is synchronous, active high, and clears state and configuration.
module slew_limited_power_regulator_core import srpr_pkg::*; #(
   parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   srpr_req_if.sink              req_ch,
   srpr_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_APPLY = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   cfg_type        cfg;
   div_status_type div_st;
   logic [QUOT_W-1:0] quot;
   logic           holding;

   // latched item
   logic signed [BUDGET_W-1:0] budget_ff;
   logic [TARGET_W-1:0]        target_ff;
   logic                       enable_ff, boost_ff, fault_ff;

   logic [PCT_W-1:0]  cur_ff, cur_in;
   logic [PROD_W-1:0] prod_ff;
   logic [NUM_W-1:0]  num_scaled;
   logic [BUDGET_W-1:0] mag;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0] rsp_pct_ff;
   logic             rsp_changed_ff, rsp_hold_ff;

   logic accept, apply_fire;

   logic signed [BUDGET_W-1:0] cur_s, lim_s, tgt_s, dz_s, step_s, nv;
   logic [STEP_W-1:0]          step_mag;
   logic [PCT_W-1:0]           new_pct;

   srpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srpr_wdog #(.COUNTER_BITS(COUNTER_BITS)) u_wdog (
      .clock    (clock),
      .reset    (reset),
      .tick     (accept),
      .kick     (req_ch.link_kick),
      .clear    (apply_fire && !enable_ff),
      .timeout  (cfg.wd_timeout),
      .recovery (cfg.wd_recovery),
      .holding  (holding)
   );

   assign num_scaled = NUM_W'(prod_ff) * NUM_W'(SCALE_PCT);

   srpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SCALE),
      .dividend (num_scaled[NUM_W-1:4]),
      .divisor  (cfg.rated_power),
      .quot     (quot),
      .status   (div_st)
   );

   assign accept     = req_ch.valid && req_ch.ready;
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == ST_IDLE);

   // magnitude of the budget; the most negative code maps to 2^17
   assign mag = budget_ff[BUDGET_W-1] ? (~budget_ff + 1'b1) : budget_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MUL;
         ST_MUL:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIV;
         ST_DIV:   if (div_st.done) state_in = ST_APPLY;
         ST_APPLY: if (apply_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // new output value
   always_comb begin
      cur_s = signed'(BUDGET_W'(cur_ff));
      lim_s = signed'(BUDGET_W'(cfg.step_limit));
      tgt_s = signed'(BUDGET_W'({target_ff, 8'b0}));
      dz_s  = signed'(BUDGET_W'(cfg.dead_zone));
      if (div_st.ovf || (quot > QUOT_W'(cfg.step_limit)))
         step_mag = cfg.step_limit;
      else
         step_mag = quot[STEP_W-1:0];
      step_s = budget_ff[BUDGET_W-1] ? -signed'(BUDGET_W'(step_mag))
                                     : signed'(BUDGET_W'(step_mag));
      nv = cur_s;
      if (holding || !enable_ff || fault_ff) begin
         if (cur_ff != '0) nv = cur_s - lim_s;
      end else if (boost_ff) begin
         nv = signed'(BUDGET_W'(FULL_SCALE_Q8));
      end else if (cfg.percent_mode) begin
         if (tgt_s > cur_s) begin
            nv = cur_s + lim_s;
            if (nv > tgt_s) nv = tgt_s;
         end else if (tgt_s < cur_s) begin
            nv = cur_s - lim_s;
            if (nv < tgt_s) nv = tgt_s;
         end
      end else if ((budget_ff > dz_s) || (budget_ff < -dz_s)) begin
         nv = cur_s + step_s;
      end
      if (nv > signed'(BUDGET_W'(FULL_SCALE_Q8)))
         new_pct = PCT_W'(FULL_SCALE_Q8);
      else if (nv < 0)
         new_pct = '0;
      else
         new_pct = nv[PCT_W-1:0];
   end

   assign cur_in = apply_fire ? new_pct : cur_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire)
         rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         budget_ff <= req_ch.budget_watts;
         target_ff <= req_ch.target_percent;
         enable_ff <= req_ch.control_enable;
         boost_ff  <= req_ch.boost;
         fault_ff  <= req_ch.fault;
      end
      if (state_ff == ST_MUL)
         prod_ff <= PROD_W'(cfg.error_gain) * PROD_W'(mag);
      if (apply_fire) begin
         rsp_pct_ff     <= new_pct;
         rsp_changed_ff <= (new_pct != cur_ff);
         rsp_hold_ff    <= holding && enable_ff;   // control off clears the hold
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.output_percent_q8 = rsp_pct_ff;
   assign rsp_ch.output_changed    = rsp_changed_ff;
   assign rsp_ch.watchdog_holding  = rsp_hold_ff;

endmodule

// ===== src/srpr_checker.sv =====
module srpr_checker import srpr_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PCT_W-1:0] rsp_pct
);

   // nothing shown straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pct))
      else $error("stalled result changed");

   // output stays within 0..100 %
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pct <= PCT_W'(FULL_SCALE_Q8))
      else $error("output percentage above full scale");

   // one item at a time: busy after every accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after accept");

endmodule

bind slew_limited_power_regulator_core srpr_checker u_srpr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pct   (rsp_ch.output_percent_q8)
);

// ===== tb/srpr_output_check.sv =====
`timescale 1ns / 1ps

module srpr_output_check import srpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   srpr_req_if                   req_ch,
   srpr_rsp_if                   rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [PCT_W-1:0] level;
      logic             changed;
      logic             holding;
   } level_type;

   localparam cfg_type RESET_SETTINGS = '{
      percent_mode: 1'b0,
      rated_power:  16'd2000,
      dead_zone:    8'd10,
      error_gain:   16'd4096,
      step_limit:   15'd256,
      wd_timeout:   24'd0,
      wd_recovery:  24'd0
   };

   cfg_type            settings;
   logic [PCT_W-1:0]   level_now;
   logic [TICKS_W-1:0] ticks_since_kick;
   logic [TICKS_W-1:0] hold_left;
   level_type          expected_levels[$];

   function automatic level_type regulate_tick(
      input logic signed [BUDGET_W-1:0] budget,
      input logic [TARGET_W-1:0]        target_pct,
      input logic                       enable,
      input logic                       boost,
      input logic                       fault,
      input logic                       kick
   );
      longint    cur, lim, nv, target_q8, dz, bud, mag, quot, step, full;
      level_type res;
      cur       = longint'(level_now);
      lim       = longint'(settings.step_limit);
      nv        = cur;
      target_q8 = longint'(target_pct) << 8;
      dz        = longint'(settings.dead_zone);
      bud       = longint'(budget);
      full      = longint'(FULL_SCALE_Q8);

      // watchdog runs before the level update
      if (kick)
         ticks_since_kick = '0;
      if (settings.wd_timeout != '0) begin
         if (ticks_since_kick < settings.wd_timeout) begin
            ticks_since_kick = ticks_since_kick + 1'b1;
            if (hold_left != '0)
               hold_left = hold_left - 1'b1;
         end else begin
            hold_left = settings.wd_recovery;
         end
      end

      if (hold_left != '0 || !enable || fault) begin
         if (!enable)
            hold_left = '0;
         if (cur > 0)
            nv = cur - lim;
      end else if (boost) begin
         nv = full;
      end else if (settings.percent_mode) begin
         if (target_q8 > cur) begin
            nv = cur + lim;
            if (nv > target_q8)
               nv = target_q8;
         end else if (target_q8 < cur) begin
            nv = cur - lim;
            if (nv < target_q8)
               nv = target_q8;
         end
      end else if (bud > dz || bud < -dz) begin
         mag = (bud < 0) ? -bud : bud;
         // zero rating: divider saturates, so the step is the full limit
         if (settings.rated_power == '0) begin
            step = lim;
         end else begin
            quot = (longint'(settings.error_gain) * 100 * mag) /
                   (longint'(settings.rated_power) * 16);
            step = (quot > lim) ? lim : quot;
         end
         nv = (bud < 0) ? cur - step : cur + step;
      end

      if (nv > full)
         nv = full;
      else if (nv < 0)
         nv = 0;

      res.level   = nv[PCT_W-1:0];
      res.changed = (nv != cur);
      res.holding = (hold_left != '0);
      level_now   = nv[PCT_W-1:0];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [PCT_W-1:0] want,
                              input logic [PCT_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      level_type want;
      if (reset) begin
         settings         = RESET_SETTINGS;
         level_now        = '0;
         ticks_since_kick = '0;
         hold_left        = '0;
         expected_levels.delete();
         fail_count       = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_levels.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got level %0d changed %0b holding %0b",
                        $time, rsp_ch.output_percent_q8, rsp_ch.output_changed,
                        rsp_ch.watchdog_holding);
            end else begin
               want = expected_levels.pop_front();
               check_field("output_percent_q8", want.level, rsp_ch.output_percent_q8);
               check_field("output_changed", PCT_W'(want.changed),
                           PCT_W'(rsp_ch.output_changed));
               check_field("watchdog_holding", PCT_W'(want.holding),
                           PCT_W'(rsp_ch.watchdog_holding));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_PERCENT_MODE: settings.percent_mode = csr_wdata[0];
               REG_RATED_POWER:  settings.rated_power  = csr_wdata[RATING_W-1:0];
               REG_DEAD_ZONE:    settings.dead_zone    = csr_wdata[DZONE_W-1:0];
               REG_ERROR_GAIN:   settings.error_gain   = csr_wdata[GAIN_W-1:0];
               REG_STEP_LIMIT:   settings.step_limit   = csr_wdata[STEP_W-1:0];
               REG_WD_TIMEOUT:   settings.wd_timeout   = csr_wdata[TICKS_W-1:0];
               REG_WD_RECOVERY:  settings.wd_recovery  = csr_wdata[TICKS_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_levels.push_back(regulate_tick(req_ch.budget_watts, req_ch.target_percent,
                                                    req_ch.control_enable, req_ch.boost,
                                                    req_ch.fault, req_ch.link_kick));
      end
      outstanding = expected_levels.size();
   end

endmodule

// ===== tb/slew_limited_power_regulator_core_tb.sv =====
`timescale 1ns / 1ps

module slew_limited_power_regulator_core_tb;
   import srpr_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;
   bit                    quiet = 1'b0;

   srpr_req_if req_if ();
   srpr_rsp_if rsp_if ();

   slew_limited_power_regulator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srpr_output_check output_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("slew_limited_power_regulator_core_tb failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_cycles();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 20);
      return $urandom_range(40, 120);
   endfunction

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(0, 30)) @(negedge clock);
      end
   end

   task automatic send_tick(input logic signed [BUDGET_W-1:0] budget,
                            input logic [TARGET_W-1:0] target_pct, input logic enable,
                            input logic boost, input logic fault, input logic kick);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.budget_watts   <= budget;
      req_if.target_percent <= target_pct;
      req_if.control_enable <= enable;
      req_if.boost          <= boost;
      req_if.fault          <= fault;
      req_if.link_kick      <= kick;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_tick();
      logic signed [BUDGET_W-1:0] budget;
      logic [TARGET_W-1:0]        target_pct;
      int                         r;
      int                         mag;
      r = $urandom_range(0, 9);
      if (r < 4)
         mag = $urandom_range(0, 300);
      else if (r < 7)
         mag = $urandom_range(0, 5000);
      else
         mag = $urandom_range(0, 100000);
      budget = BUDGET_W'($urandom_range(0, 1) ? -mag : mag);
      if (r == 9)
         budget = BUDGET_W'($urandom());
      if ($urandom_range(0, 6) == 0)
         target_pct = TARGET_W'($urandom_range(0, 127));
      else
         target_pct = TARGET_W'($urandom_range(0, 100));
      send_tick(budget, target_pct, $urandom_range(0, 9) != 0, $urandom_range(0, 19) == 0,
                $urandom_range(0, 11) == 0, $urandom_range(0, 9) < 7);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      write_reg(REG_PERCENT_MODE, CSR_DATA_W'(c.percent_mode));
      write_reg(REG_RATED_POWER,  CSR_DATA_W'(c.rated_power));
      write_reg(REG_DEAD_ZONE,    CSR_DATA_W'(c.dead_zone));
      write_reg(REG_ERROR_GAIN,   CSR_DATA_W'(c.error_gain));
      write_reg(REG_STEP_LIMIT,   CSR_DATA_W'(c.step_limit));
      write_reg(REG_WD_TIMEOUT,   CSR_DATA_W'(c.wd_timeout));
      write_reg(REG_WD_RECOVERY,  CSR_DATA_W'(c.wd_recovery));
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type pick_settings();
      cfg_type c;
      c.percent_mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       c.rated_power = '0;
         1:       c.rated_power = 16'd100;
         2:       c.rated_power = 16'hFFFF;
         default: c.rated_power = RATING_W'($urandom_range(100, 5000));
      endcase
      case ($urandom_range(0, 4))
         0:       c.dead_zone = '0;
         1:       c.dead_zone = 8'hFF;
         default: c.dead_zone = DZONE_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
         0:       c.error_gain = '0;
         1:       c.error_gain = 16'hFFFF;
         2:       c.error_gain = 16'd4096;
         default: c.error_gain = GAIN_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
         0:       c.step_limit = '0;
         1:       c.step_limit = 15'd25600;
         2:       c.step_limit = 15'h7FFF;
         default: c.step_limit = STEP_W'($urandom_range(1, 2000));
      endcase
      case ($urandom_range(0, 5))
         0, 1:    c.wd_timeout = '0;
         2:       c.wd_timeout = 24'hFFFFFF;
         default: c.wd_timeout = TICKS_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 4))
         0:       c.wd_recovery = '0;
         1:       c.wd_recovery = 24'hFFFFFF;
         default: c.wd_recovery = TICKS_W'($urandom_range(1, 12));
      endcase
      return c;
   endfunction

   initial begin
      cfg_type c;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = REG_PERCENT_MODE;
      csr_wdata             = '0;
      req_if.valid          = 1'b0;
      req_if.budget_watts   = '0;
      req_if.target_percent = '0;
      req_if.control_enable = 1'b0;
      req_if.boost          = 1'b0;
      req_if.fault          = 1'b0;
      req_if.link_kick      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // budget mode on reset settings: dead zone edges, budget extremes, overrides
      send_tick(18'sd0, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd10, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd11, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(-18'sd11, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd100000, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd131071, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(-18'sd131072, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(-18'sd100000, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd0, 7'd0, 1'b1, 1'b1, 1'b0, 1'b1);
      send_tick(18'sd0, 7'd0, 1'b1, 1'b0, 1'b1, 1'b1);
      send_tick(18'sd0, 7'd100, 1'b0, 1'b1, 1'b0, 1'b0);

      // percent mode, target above 100 included
      wait_idle();
      c = '{percent_mode: 1'b1, rated_power: 16'd2000, dead_zone: 8'd10, error_gain: 16'd4096,
            step_limit: 15'd3000, wd_timeout: 24'd0, wd_recovery: 24'd0};
      apply_settings(c);
      send_tick(18'sd0, 7'd127, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd0, 7'd127, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd0, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd0, 7'd100, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd0, 7'd50, 1'b1, 1'b0, 1'b0, 1'b1);

      // zero rating, step limit above full scale, watchdog expiry and recovery
      wait_idle();
      c = '{percent_mode: 1'b0, rated_power: 16'd0, dead_zone: 8'd255, error_gain: 16'hFFFF,
            step_limit: 15'h7FFF, wd_timeout: 24'd2, wd_recovery: 24'd3};
      apply_settings(c);
      repeat (5) send_tick(18'sd100000, 7'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      repeat (2) send_tick(18'sd100000, 7'd0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(18'sd100000, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);

      for (int phase = 0; phase < 12; phase++) begin
         wait_idle();
         apply_settings(pick_settings());
         quiet = ($urandom_range(0, 3) == 0);
         repeat (163) send_random_tick();
      end
      quiet = 1'b0;

      wait_idle();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("slew_limited_power_regulator_core_tb passed");
      else
         $display("slew_limited_power_regulator_core_tb failed");
      $finish;
   end

endmodule
